// File: design/tfbs_pkg.sv
// Shared types and constants for the transmit frame and byte statistics bank.
`timescale 1ns / 1ps

package tfbs_pkg;

    localparam int NUM_PORTS_DEF     = 16;
    localparam int DISP_PER_PORT_DEF = 16;

    localparam int PORT_W = 4;
    localparam int DISP_W = 4;
    localparam int LEN_W  = 16;
    localparam int CNT_W  = 48;

    // One transmitted frame.
    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic [DISP_W-1:0] disposition;
        logic [LEN_W-1:0]  stats_length;
        logic [LEN_W-1:0]  frame_length;
    } tfbs_in_t;

    // Updated counts for one frame.
    typedef struct packed {
        logic [PORT_W-1:0] out_port;
        logic [LEN_W-1:0]  out_length;
        logic [CNT_W-1:0]  frame_total;
        logic [CNT_W-1:0]  byte_total;
    } tfbs_out_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_in;
        logic clr_en;
        logic rd_en;
        logic wr_en;
        logic out_load;
    } tfbs_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic clr_done;
        logic in_range;
        logic out_free;
    } tfbs_status_t;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_READ  = 4'b0100,
        ST_WRITE = 4'b1000
    } tfbs_state_t;

endpackage

// File: design/tfbs_ctrl.sv
// Sequencer for the counter clearing pass and the per-item read-modify-write.
`timescale 1ns / 1ps

module tfbs_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tfbs_pkg::tfbs_status_t status,
    output tfbs_pkg::tfbs_cmd_t    cmd
);

    tfbs_pkg::tfbs_state_t state_reg;
    tfbs_pkg::tfbs_state_t state_next;

    // Hold state, clear pass first after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tfbs_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Decode commands and advance
    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            tfbs_pkg::ST_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (status.clr_done) begin
                    state_next = tfbs_pkg::ST_IDLE;
                end
            end
            tfbs_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
                if (s_valid) begin
                    state_next = tfbs_pkg::ST_READ;
                end
            end
            tfbs_pkg::ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = tfbs_pkg::ST_WRITE;
            end
            tfbs_pkg::ST_WRITE: begin
                // Wait for the output register to free up, then commit
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.wr_en    = status.in_range;
                    state_next   = tfbs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tfbs_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

// File: design/tfbs_dpath.sv
// Counter memory, adders, input capture and output register.
`timescale 1ns / 1ps

module tfbs_dpath #(
    parameter int NUM_PORTS     = tfbs_pkg::NUM_PORTS_DEF,
    parameter int DISP_PER_PORT = tfbs_pkg::DISP_PER_PORT_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tfbs_pkg::tfbs_in_t     s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output tfbs_pkg::tfbs_out_t    m_data,
    input  tfbs_pkg::tfbs_cmd_t    cmd,
    output tfbs_pkg::tfbs_status_t status
);

    localparam int BANK_DEPTH = NUM_PORTS * DISP_PER_PORT;
    localparam int IDX_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int CNT_W      = tfbs_pkg::CNT_W;

    tfbs_pkg::tfbs_in_t  in_reg;
    tfbs_pkg::tfbs_out_t out_reg;
    logic                m_valid_reg;
    logic                m_valid_next;
    logic [IDX_W-1:0]    clr_cnt_reg;
    logic [IDX_W-1:0]    clr_cnt_next;

    logic [2*CNT_W-1:0]  bank_mem [BANK_DEPTH];
    logic [2*CNT_W-1:0]  rd_data_reg;

    logic                in_range;
    logic [IDX_W-1:0]    bank_idx;
    logic [CNT_W-1:0]    frame_sum;
    logic [CNT_W-1:0]    byte_sum;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [2*CNT_W-1:0]  mem_wdata;

    // Capture the accepted item
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_data;
        end
    end

    // Select the counter entry, park the address on zero when out of range
    always_comb begin
        in_range = (int'(in_reg.port) < NUM_PORTS) &&
                   (int'(in_reg.disposition) < DISP_PER_PORT);
        bank_idx = '0;
        if (in_range) begin
            bank_idx = IDX_W'(int'(in_reg.port) * DISP_PER_PORT + int'(in_reg.disposition));
        end
    end

    // Add to the stored counts, wrapping at the counter width
    assign frame_sum = rd_data_reg[2*CNT_W-1:CNT_W] + CNT_W'(1);
    assign byte_sum  = rd_data_reg[CNT_W-1:0] + CNT_W'(in_reg.stats_length);

    // Write port: clearing pass or update
    assign mem_we    = cmd.clr_en | cmd.wr_en;
    assign mem_waddr = cmd.clr_en ? clr_cnt_reg : bank_idx;
    assign mem_wdata = cmd.clr_en ? '0 : {frame_sum, byte_sum};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            bank_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= bank_mem[bank_idx];
        end
    end

    // Advance the clear address
    assign clr_cnt_next = cmd.clr_en ? clr_cnt_reg + IDX_W'(1) : clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Load the result, zero totals when the entry does not exist
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.out_port    <= in_reg.port;
            out_reg.out_length  <= in_reg.frame_length;
            out_reg.frame_total <= in_range ? frame_sum : '0;
            out_reg.byte_total  <= in_range ? byte_sum : '0;
        end
    end

    // Hold the result until taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign status.clr_done = (clr_cnt_reg == IDX_W'(BANK_DEPTH - 1));
    assign status.in_range = in_range;
    assign status.out_free = !m_valid_reg || m_ready;

endmodule

// File: design/tx_frame_byte_stats_bank.sv
// Top level of the transmit frame and byte statistics bank.
//
// Keeps a 48-bit frame counter and a 48-bit byte counter for each of
// NUM_PORTS * DISP_PER_PORT entries (port * DISP_PER_PORT + disposition) in a
// single-port memory. Each item is accepted, read from memory, then added to
// and written back while the result loads into the output register; the
// last step waits while an earlier result is still held on the output.
// Frames whose port or disposition select no entry change nothing and report
// zero totals. After reset the block clears all NUM_PORTS * DISP_PER_PORT
// entries (256 by default) one entry per cycle, with s_ready low.
`timescale 1ns / 1ps

module tx_frame_byte_stats_bank #(
    parameter int NUM_PORTS     = tfbs_pkg::NUM_PORTS_DEF,
    parameter int DISP_PER_PORT = tfbs_pkg::DISP_PER_PORT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tfbs_pkg::tfbs_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tfbs_pkg::tfbs_out_t m_data
);

    tfbs_pkg::tfbs_cmd_t    cmd;
    tfbs_pkg::tfbs_status_t status;

    tfbs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tfbs_dpath #(
        .NUM_PORTS     (NUM_PORTS),
        .DISP_PER_PORT (DISP_PER_PORT)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .status  (status)
    );

endmodule

// File: design/tfbs_chk.sv
// Port-level checker for the statistics bank, bound to the top level.
`timescale 1ns / 1ps

module tfbs_chk #(
    parameter int NUM_PORTS     = tfbs_pkg::NUM_PORTS_DEF,
    parameter int DISP_PER_PORT = tfbs_pkg::DISP_PER_PORT_DEF
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input tfbs_pkg::tfbs_in_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input tfbs_pkg::tfbs_out_t m_data
);

    // One item at a time: no accept right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an item is in flight");

    // A new result appears as the block returns to idle
    a_result_at_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result appeared while block busy");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed or dropped");

    // Frames whose port has no counter entry report zero totals
    a_zero_unmapped: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (int'(m_data.out_port) >= NUM_PORTS))
        |-> (m_data.frame_total == '0 && m_data.byte_total == '0))
        else $error("nonzero totals for unmapped port");

    // A waiting input item holds until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=> (s_valid && $stable(s_data)))
        else $error("waiting input item changed or dropped");

endmodule

bind tx_frame_byte_stats_bank tfbs_chk #(
    .NUM_PORTS     (NUM_PORTS),
    .DISP_PER_PORT (DISP_PER_PORT)
) u_tfbs_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
